### rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared constants and types for the sync/length/checksum frame receiver.
// ----------------------------------------------------------------------------
package slcd_pkg;

  localparam int          MAX_PAYLOAD_DEF = 32;

  localparam logic [7:0]  SYNC_FIRST      = 8'd125;
  localparam logic [7:0]  SYNC_SECOND     = 8'd126;
  localparam logic [8:0]  SUM_MODULUS     = 9'd255;

  // Receive sequencer states
  typedef enum logic [3:0] {
    ST_SYNC1,
    ST_SYNC2,
    ST_SRC,
    ST_DST,
    ST_SEQH,
    ST_SEQL,
    ST_LEN,
    ST_PAY,
    ST_CHECK,
    ST_READ,
    ST_SHOW
  } slcd_state_t;

  // Checksum unit operation
  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_CLEAR,
    SUM_ADD
  } sum_op_t;

  // Payload buffer strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Checksum unit status
  typedef struct packed {
    logic match;
  } sum_stat_t;

endpackage

### rtl/slcd_buf.sv
// ----------------------------------------------------------------------------
// slcd_buf
// Payload byte buffer: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module slcd_buf
  import slcd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wr_data,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [MAX_PAYLOAD];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

### rtl/slcd_sum.sv
// ----------------------------------------------------------------------------
// slcd_sum
// Running payload sum mod 255 and checksum compare on one shared adder.
// ----------------------------------------------------------------------------
module slcd_sum
  import slcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sum_op_t    op,
  input  logic [7:0] din,
  output sum_stat_t  stat
);

  logic [7:0] sum_mod;
  logic [7:0] sum_mod_next;
  logic [8:0] total;

  // sum_mod <= 254, so total <= 509 and one subtract reduces it.
  // Checksum 255 - sum_mod matches exactly when sum_mod + byte == 255.
  assign total        = {1'b0, sum_mod} + {1'b0, din};
  assign sum_mod_next = (total >= SUM_MODULUS) ? 8'(total - SUM_MODULUS) : total[7:0];
  assign stat.match   = (total == SUM_MODULUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_mod <= 8'd0;
    end else begin
      case (op)
        SUM_CLEAR: sum_mod <= 8'd0;
        SUM_ADD:   sum_mod <= sum_mod_next;
        default:   sum_mod <= sum_mod;
      endcase
    end
  end

endmodule

### rtl/slcd_seq.sv
// ----------------------------------------------------------------------------
// slcd_seq
// Frame sequencer: header capture, payload count, result emission.
// ----------------------------------------------------------------------------
module slcd_seq
  import slcd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  parameter int CW          = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic          clk,
  input  logic          rst,
  // receive side
  input  logic          rx_valid,
  output logic          rx_stall,
  input  logic [7:0]    rx_byte,
  // result side
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    src_addr,
  output logic [7:0]    dst_addr,
  output logic [15:0]   seq_number,
  output logic [5:0]    payload_len,
  output logic [4:0]    byte_index,
  output logic          has_data,
  output logic          last,
  // shared units
  output sum_op_t       sum_op,
  input  sum_stat_t     sum_stat,
  output mem_ctl_t      mem_ctl,
  output logic [AW-1:0] mem_addr
);

  slcd_state_t   state;
  slcd_state_t   state_next;
  logic [CW-1:0] idx;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] hdr_len;
  logic [7:0]    hdr_src;
  logic [7:0]    hdr_dst;
  logic [15:0]   hdr_seq;
  logic          rx_take;
  logic          out_take;
  logic          len_ok;

  assign rx_take  = rx_valid && !rx_stall;
  assign out_take = out_valid && !out_stall;
  assign idx_inc  = idx + CW'(1);
  assign len_ok   = (rx_byte <= 8'(MAX_PAYLOAD));
  assign mem_addr = idx[AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_SYNC1: if (rx_take && rx_byte == SYNC_FIRST) state_next = ST_SYNC2;
      ST_SYNC2: if (rx_take) state_next = (rx_byte == SYNC_SECOND) ? ST_SRC : ST_SYNC1;
      ST_SRC:   if (rx_take) state_next = ST_DST;
      ST_DST:   if (rx_take) state_next = ST_SEQH;
      ST_SEQH:  if (rx_take) state_next = ST_SEQL;
      ST_SEQL:  if (rx_take) state_next = ST_LEN;
      ST_LEN: begin
        if (rx_take) begin
          if (!len_ok) begin
            state_next = ST_SYNC1;
          end else if (rx_byte == 8'd0) begin
            state_next = ST_CHECK;
          end else begin
            state_next = ST_PAY;
          end
        end
      end
      ST_PAY:   if (rx_take && idx_inc == hdr_len) state_next = ST_CHECK;
      ST_CHECK: begin
        if (rx_take) begin
          if (!sum_stat.match) begin
            state_next = ST_SYNC1;
          end else if (hdr_len == '0) begin
            state_next = ST_SHOW;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:  state_next = ST_SHOW;
      ST_SHOW:  if (out_take) state_next = last ? ST_SYNC1 : ST_READ;
      default:  state_next = ST_SYNC1;
    endcase
  end

  // control outputs
  always_comb begin
    rx_stall      = (state == ST_READ) || (state == ST_SHOW);
    out_valid     = (state == ST_SHOW);
    mem_ctl.wr_en = (state == ST_PAY) && rx_take;
    mem_ctl.rd_en = (state == ST_READ);
    sum_op        = SUM_HOLD;
    unique case (state)
      ST_LEN:   if (rx_take) sum_op = SUM_CLEAR;
      ST_PAY:   if (rx_take) sum_op = SUM_ADD;
      ST_CHECK: if (rx_take) sum_op = SUM_CLEAR;
      default:  sum_op = SUM_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SYNC1;
    end else begin
      state <= state_next;
    end
  end

  // header and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      hdr_len <= '0;
      hdr_src <= 8'd0;
      hdr_dst <= 8'd0;
      hdr_seq <= 16'd0;
    end else begin
      if (rx_take) begin
        case (state)
          ST_SRC:  hdr_src <= rx_byte;
          ST_DST:  hdr_dst <= rx_byte;
          ST_SEQH: hdr_seq <= {rx_byte, 8'd0};
          ST_SEQL: hdr_seq[7:0] <= rx_byte;
          ST_LEN: begin
            if (len_ok) begin
              hdr_len <= CW'(rx_byte);
              idx     <= '0;
            end
          end
          ST_PAY:   idx <= idx_inc;
          ST_CHECK: idx <= '0;
          default:  idx <= idx;
        endcase
      end else if (out_take) begin
        idx <= idx_inc;
      end
    end
  end

  assign src_addr    = hdr_src;
  assign dst_addr    = hdr_dst;
  assign seq_number  = hdr_seq;
  assign payload_len = 6'(hdr_len);
  assign byte_index  = 5'(idx);
  assign has_data    = (hdr_len != '0);
  assign last        = !has_data || (idx_inc == hdr_len);

  // no input taken while a result is pending
  a_stall_on_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rx_stall)
    else $error("input accepted while emitting");

  // payload count stays below the frame length
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAY || state == ST_READ || state == ST_SHOW) && has_data |-> idx < hdr_len)
    else $error("payload index out of range");

  // an empty frame gives a single final result
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_data |-> last && idx == '0)
    else $error("empty frame result malformed");

  // final result returns the receiver to sync hunt
  a_back_to_sync: assert property (@(posedge clk) disable iff (rst)
    out_take && last |=> !out_valid && !rx_stall)
    else $error("no return to sync after last result");

endmodule

### rtl/sync_length_checksum_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Byte-wide frame receiver: sync pair, header, length-prefixed payload and
// mod-255 checksum; good frames replay one word per byte (empty: one word).
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  rx      | rx_valid / rx_stall  | rx_byte
//  out     | out_valid / out_stall| src_addr dst_addr seq_number payload_len
//          |                      | byte_index payload_byte has_data last
//
//  Receive: one rx word per cycle while hunting/receiving a frame.
//  Emit: each payload byte of a good frame is first read from the buffer,
//  then shown; an empty frame is shown as a single result. rx_stall is high
//  throughout. Each result waits in place while out_stall is high.
//  Reset (rst, synchronous) clears sequencer, header and checksum state; the
//  payload buffer is not cleared, only bytes of the current frame are read.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer
  import slcd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  src_addr,
  output logic [7:0]  dst_addr,
  output logic [15:0] seq_number,
  output logic [5:0]  payload_len,
  output logic [4:0]  byte_index,
  output logic [7:0]  payload_byte,
  output logic        has_data,
  output logic        last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  sum_op_t       sum_op;
  sum_stat_t     sum_stat;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [7:0]    rd_data;

  // Sequencer: walks the frame layout, drives the adder and the buffer.
  slcd_seq #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .src_addr    (src_addr),
    .dst_addr    (dst_addr),
    .seq_number  (seq_number),
    .payload_len (payload_len),
    .byte_index  (byte_index),
    .has_data    (has_data),
    .last        (last),
    .sum_op      (sum_op),
    .sum_stat    (sum_stat),
    .mem_ctl     (mem_ctl),
    .mem_addr    (mem_addr)
  );

  // One adder serves both the running sum and the checksum compare.
  slcd_sum u_sum (
    .clk  (clk),
    .rst  (rst),
    .op   (sum_op),
    .din  (rx_byte),
    .stat (sum_stat)
  );

  // Payload bytes are held here until the checksum clears the frame.
  slcd_buf #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_buf (
    .clk     (clk),
    .ctl     (mem_ctl),
    .addr    (mem_addr),
    .wr_data (rx_byte),
    .rd_data (rd_data)
  );

  // Empty frames show a zero data byte.
  assign payload_byte = has_data ? rd_data : 8'd0;

endmodule
